// ===== design/greedy_text_justifier_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the justifier back end.
// ----------------------------------------------------------------------------
`ifndef GREEDY_TEXT_JUSTIFIER_CORE_MACROS_SVH
`define GREEDY_TEXT_JUSTIFIER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GTJ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GTJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gtj_pkg.sv =====
// ----------------------------------------------------------------------------
// gtj_pkg
// Types and constants shared by the text justifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gtj_pkg;

    localparam int MAX_LINE  = 32;
    localparam int MAX_WORDS = 16;

    localparam logic [7:0] SPACE_CODE  = 8'h20;
    localparam logic [5:0] WIDTH_RESET = 6'd16;

    // One input item.
    typedef struct packed {
        logic [7:0] ch;
        logic       word_end;
        logic       text_end;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_ch;
        logic       line_end;
        logic       text_done;
    } t_out_item;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       word_end;
        logic       text_end;
    } t_cmd_chan;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT,
        ST_COPY
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/greedy_text_justifier_core.sv =====
// ----------------------------------------------------------------------------
// greedy_text_justifier_core
// Greedy full justification of a character stream into fixed-width lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (one character with word_end and text_end flags) are pushed
//   with i_push while o_full is low. Result items (one output character with
//   line_end and text_done flags) wait on o_item while o_empty is low and are
//   taken with i_pop. The line width register is written with i_cfg_we and
//   i_cfg_data; the user must write it only while the block is idle, as the
//   block itself does not enforce this. It resets to 16.
//   Sequencing: the back end takes each character in turn, copies a finished
//   word into the line store character by character plus a closing step, and
//   emits a line character by character with a start step for each word. A
//   fully justified line first runs a serial padding division. The closing
//   line of a text starts once its final word is copied.
//   Reset clears the held line, the pending word and both queues.
//   When the receiver stalls, the result queue fills, emission pauses, and the
//   input queue keeps accepting until it holds two items.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_text_justifier_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  gtj_pkg::t_in_item      i_item,
    output logic                   o_full,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output gtj_pkg::t_out_item     o_item,
    input  wire logic              i_cfg_we,
    input  wire logic [5:0]        i_cfg_data
);

    logic [5:0]          r_line_width;
    logic [5:0]          w_width;
    gtj_pkg::t_cmd_chan  w_cmd;
    logic                w_cmd_pop;
    logic                w_oq_full;
    logic                w_oq_push;
    gtj_pkg::t_out_item  w_oq_item;

    // Line width register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= gtj_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_line_width <= i_cfg_data;
        end
    end

    // Clamp the width into the supported range.
    always_comb begin
        if (r_line_width == 6'd0) begin
            w_width = 6'd1;
        end else if (r_line_width > 6'(gtj_pkg::MAX_LINE)) begin
            w_width = 6'(gtj_pkg::MAX_LINE);
        end else begin
            w_width = r_line_width;
        end
    end

    gtj_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .o_cmd   (w_cmd),
        .i_pop   (w_cmd_pop)
    );

    gtj_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (w_width),
        .i_cmd     (w_cmd),
        .o_cmd_pop (w_cmd_pop),
        .i_oq_full (w_oq_full),
        .o_oq_push (w_oq_push),
        .o_oq_item (w_oq_item)
    );

    gtj_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_oq_push),
        .i_item  (w_oq_item),
        .o_full  (w_oq_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

// ===== design/gtj_front.sv =====
// ----------------------------------------------------------------------------
// gtj_front
// Accepts input items into a two-entry queue and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module gtj_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  gtj_pkg::t_in_item      i_item,
    output logic                   o_full,
    output gtj_pkg::t_cmd_chan     o_cmd,
    input  wire logic              i_pop
);

    gtj_pkg::t_in_item r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full = (r_cnt == 2'd2);
    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && (r_cnt != 2'd0);

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Classify: a text end only counts together with a word end.
    always_comb begin
        o_cmd.valid    = (r_cnt != 2'd0);
        o_cmd.ch       = r_mem[r_rp].ch;
        o_cmd.word_end = r_mem[r_rp].word_end;
        o_cmd.text_end = r_mem[r_rp].text_end && r_mem[r_rp].word_end;
    end

endmodule

`default_nettype wire

// ===== design/gtj_outq.sv =====
// ----------------------------------------------------------------------------
// gtj_outq
// Two-entry result queue that decouples the back end from the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module gtj_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  gtj_pkg::t_out_item     i_item,
    output logic                   o_full,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output gtj_pkg::t_out_item     o_item
);

    gtj_pkg::t_out_item r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/gtj_back.sv =====
// ----------------------------------------------------------------------------
// gtj_back
// Sequencer that collects words, packs lines and emits justified lines.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_text_justifier_core_macros.svh"

module gtj_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [5:0]        i_width,
    input  gtj_pkg::t_cmd_chan     i_cmd,
    output logic                   o_cmd_pop,
    input  wire logic              i_oq_full,
    output logic                   o_oq_push,
    output gtj_pkg::t_out_item     o_oq_item
);

    gtj_pkg::t_back_state r_state, n_state;

    // Stores.
    logic [7:0] r_pend [gtj_pkg::MAX_LINE];
    logic [7:0] r_line [gtj_pkg::MAX_LINE];
    logic [5:0] r_wlen [gtj_pkg::MAX_WORDS];

    // Line state.
    logic [5:0] r_plen;
    logic [4:0] r_wc;
    logic [5:0] r_letters;
    logic [5:0] r_len;
    logic       r_text;
    logic       r_left;
    logic       r_last;

    // Divider.
    logic [5:0] r_base;
    logic [4:0] r_rem;
    logic [5:0] r_dq;
    logic [4:0] r_dr;
    logic [2:0] r_dcnt;

    // Line walker and copy counter.
    logic [5:0] r_pos;
    logic [4:0] r_w;
    logic [5:0] r_c;
    logic [5:0] r_gap;
    logic [5:0] r_src;
    logic [5:0] r_i;

    logic       w_store;
    logic [5:0] w_plen_new;
    logic [5:0] w_len;
    logic [6:0] w_fit_sum;
    logic       w_emit_need;
    logic [4:0] w_gaps;
    logic       w_div_need;
    logic [5:0] w_div_t;
    logic       w_div_bit;
    logic [4:0] w_div_r;
    logic       w_gap_on;
    logic       w_char_on;
    logic       w_start_word;
    logic       w_emit_fire;
    logic       w_line_last;
    logic [5:0] w_gap_val;
    logic [6:0] w_at;
    logic       w_copy_done;

    // Word-end decision on the item at the head of the queue.
    always_comb begin
        w_store     = (r_plen < i_width);
        w_plen_new  = r_plen + {5'd0, w_store};
        w_len       = (w_plen_new < i_width) ? w_plen_new : i_width;
        w_fit_sum   = {1'b0, r_letters} + {2'b0, r_wc} + {1'b0, w_len};
        w_emit_need = (r_wc != 5'd0) &&
                      ((r_wc >= 5'(gtj_pkg::MAX_WORDS)) || (w_fit_sum > {1'b0, i_width}));
        w_gaps      = (r_wc != 5'd0) ? (r_wc - 5'd1) : 5'd0;
        w_div_need  = (r_wc != 5'd1) && (w_gaps != 5'd0) &&
                      (({1'b0, r_letters} + {2'b0, w_gaps}) <= {1'b0, i_width});
    end

    // One restoring division step per cycle: padding over gaps.
    always_comb begin
        w_div_t   = {r_dr, r_dq[5]};
        w_div_bit = (w_div_t >= {1'b0, w_gaps});
        w_div_r   = w_div_bit ? 5'(w_div_t - {1'b0, w_gaps}) : w_div_t[4:0];
    end

    // Line walker: gap spaces, then word letters, then right padding.
    always_comb begin
        w_gap_on     = (r_gap != 6'd0);
        w_char_on    = !w_gap_on && (r_c != 6'd0);
        w_start_word = !w_gap_on && !w_char_on && (r_w < r_wc);
        w_line_last  = (r_pos == (i_width - 6'd1));
        w_gap_val    = (r_w == 5'd0) ? 6'd0 :
                       r_base + {5'd0, ((r_w - 5'd1) < r_rem)};
        w_at         = {1'b0, r_letters} + {1'b0, r_i};
        w_copy_done  = (r_i >= r_len);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtj_pkg::ST_IDLE: begin
                if (i_cmd.valid && i_cmd.word_end) begin
                    if (w_emit_need) begin
                        n_state = w_div_need ? gtj_pkg::ST_DIV : gtj_pkg::ST_EMIT;
                    end else begin
                        n_state = gtj_pkg::ST_COPY;
                    end
                end
            end
            gtj_pkg::ST_DIV: begin
                if (r_dcnt == 3'd5) begin
                    n_state = gtj_pkg::ST_EMIT;
                end
            end
            gtj_pkg::ST_EMIT: begin
                if (w_emit_fire && w_line_last) begin
                    n_state = r_last ? gtj_pkg::ST_IDLE : gtj_pkg::ST_COPY;
                end
            end
            gtj_pkg::ST_COPY: begin
                if (w_copy_done) begin
                    n_state = r_text ? gtj_pkg::ST_EMIT : gtj_pkg::ST_IDLE;
                end
            end
            default: n_state = gtj_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd_pop   = (r_state == gtj_pkg::ST_IDLE) && i_cmd.valid;
        w_emit_fire = (r_state == gtj_pkg::ST_EMIT) && !i_oq_full && !w_start_word;
        o_oq_push   = w_emit_fire;
        o_oq_item.out_ch    = w_char_on ? r_line[r_src[4:0]] : gtj_pkg::SPACE_CODE;
        o_oq_item.line_end  = w_line_last;
        o_oq_item.text_done = w_line_last && r_last;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gtj_pkg::ST_IDLE;
            r_plen    <= 6'd0;
            r_wc      <= 5'd0;
            r_letters <= 6'd0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop && w_store) begin
                r_plen <= w_plen_new;
            end
            if (w_emit_fire && w_line_last) begin
                r_wc      <= 5'd0;
                r_letters <= 6'd0;
            end
            if (r_state == gtj_pkg::ST_COPY && w_copy_done) begin
                if (r_wc < 5'(gtj_pkg::MAX_WORDS)) begin
                    r_wc <= r_wc + 5'd1;
                end
                r_letters <= r_letters + r_len;
                r_plen    <= 6'd0;
            end
        end
    end

    // Datapath registers and stores.
    always_ff @(posedge i_clk) begin
        case (r_state)
            gtj_pkg::ST_IDLE: begin
                if (o_cmd_pop) begin
                    if (w_store) begin
                        r_pend[r_plen[4:0]] <= i_cmd.ch;
                    end
                    r_len  <= w_len;
                    r_text <= i_cmd.text_end;
                    r_i    <= 6'd0;
                    r_left <= (r_wc == 5'd1);
                    r_last <= 1'b0;
                    r_base <= 6'd1;
                    r_rem  <= 5'd0;
                    r_dq   <= i_width - r_letters;
                    r_dr   <= 5'd0;
                    r_dcnt <= 3'd0;
                    r_pos  <= 6'd0;
                    r_w    <= 5'd0;
                    r_c    <= 6'd0;
                    r_gap  <= 6'd0;
                    r_src  <= 6'd0;
                end
            end
            gtj_pkg::ST_DIV: begin
                r_dq   <= {r_dq[4:0], w_div_bit};
                r_dr   <= w_div_r;
                r_dcnt <= r_dcnt + 3'd1;
                if (r_dcnt == 3'd5) begin
                    r_base <= {r_dq[4:0], w_div_bit};
                    r_rem  <= w_div_r;
                end
            end
            gtj_pkg::ST_EMIT: begin
                if (w_start_word) begin
                    r_gap <= w_gap_val;
                    r_c   <= r_wlen[r_w[3:0]];
                    r_w   <= r_w + 5'd1;
                end else if (w_emit_fire) begin
                    r_pos <= r_pos + 6'd1;
                    if (w_gap_on) begin
                        r_gap <= r_gap - 6'd1;
                    end else if (w_char_on) begin
                        r_c   <= r_c - 6'd1;
                        r_src <= r_src + 6'd1;
                    end
                end
            end
            gtj_pkg::ST_COPY: begin
                if (!w_copy_done) begin
                    if (w_at < 7'(gtj_pkg::MAX_LINE)) begin
                        r_line[w_at[4:0]] <= r_pend[r_i[4:0]];
                    end
                    r_i <= r_i + 6'd1;
                end else begin
                    if (r_wc < 5'(gtj_pkg::MAX_WORDS)) begin
                        r_wlen[r_wc[3:0]] <= r_len;
                    end
                    // Final line of the text: left justified.
                    r_left <= 1'b1;
                    r_last <= 1'b1;
                    r_base <= 6'd1;
                    r_rem  <= 5'd0;
                    r_pos  <= 6'd0;
                    r_w    <= 5'd0;
                    r_c    <= 6'd0;
                    r_gap  <= 6'd0;
                    r_src  <= 6'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // Checks.
    `GTJ_ASSERT_NOW(a_push_only_emit, o_oq_push, r_state == gtj_pkg::ST_EMIT, "push outside emit")
    `GTJ_ASSERT_NOW(a_div_count, r_state == gtj_pkg::ST_DIV, r_dcnt <= 3'd5, "divider overrun")
    `GTJ_ASSERT_NEXT(a_mid_line_copy, o_oq_push && o_oq_item.line_end && !r_last, r_state == gtj_pkg::ST_COPY, "no copy after early line")
    `GTJ_ASSERT_NOW(a_copy_in_range, r_state == gtj_pkg::ST_COPY && !w_copy_done, w_at < 7'(gtj_pkg::MAX_LINE), "line store overflow")
    `GTJ_ASSERT_NOW(a_left_no_div, r_state == gtj_pkg::ST_DIV, !r_left, "divide on left line")

endmodule

`default_nettype wire

// ===== sim/greedy_text_justifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// greedy_text_justifier_core_tb
// Checks the justifier against a line-packing predictor, character by
// character, over directed texts and random texts at several line widths,
// with bursty input, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_text_justifier_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    gtj_pkg::t_in_item     i_item;
    logic                  o_full;
    logic                  o_empty;
    logic                  i_pop;
    gtj_pkg::t_out_item    o_item;
    logic                  i_cfg_we;
    logic [5:0]            i_cfg_data;

    // Predictor state.
    logic [5:0]    cfg_width;
    logic [7:0]    held_letters [gtj_pkg::MAX_LINE];
    logic [5:0]    held_lengths [gtj_pkg::MAX_WORDS];
    int unsigned   held_words;
    int unsigned   held_letter_total;
    logic [7:0]    word_buf [gtj_pkg::MAX_LINE];
    int unsigned   word_buf_len;

    gtj_pkg::t_in_item   item_queue [$];
    gtj_pkg::t_out_item  expected_chars [$];
    int            error_count;
    int            idle_cycles;
    int            gap_left;
    int            burst_left;
    int            stall_phase;
    int            hold_off_left;

    greedy_text_justifier_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .o_full     (o_full),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int unsigned effective_width();
        int unsigned w;
        w = cfg_width;
        if (w < 1) w = 1;
        if (w > gtj_pkg::MAX_LINE) w = gtj_pkg::MAX_LINE;
        return w;
    endfunction

    // Appends one item to the pending input items.
    task automatic enqueue_item(input gtj_pkg::t_in_item it);
        item_queue.insert(item_queue.size(), it);
    endtask

    // Pushes one justified line of the held words onto the expected characters.
    task automatic queue_line(input bit left, input bit last);
        int unsigned width;
        int unsigned gaps;
        int unsigned base;
        int unsigned rem;
        int unsigned pos;
        int unsigned src;
        logic [7:0]  line_buf [gtj_pkg::MAX_LINE];
        gtj_pkg::t_out_item r;
        width = effective_width();
        gaps  = (held_words > 0) ? held_words - 1 : 0;
        base  = 1;
        rem   = 0;
        pos   = 0;
        src   = 0;
        if (!left && gaps > 0 && held_letter_total + gaps <= width) begin
            base = (width - held_letter_total) / gaps;
            rem  = (width - held_letter_total) % gaps;
        end
        for (int i = 0; i < gtj_pkg::MAX_LINE; i++) line_buf[i] = gtj_pkg::SPACE_CODE;
        for (int w = 0; w < held_words && w < gtj_pkg::MAX_WORDS; w++) begin
            if (w > 0) pos += base + (((w - 1) < rem) ? 1 : 0);
            for (int c = 0; c < held_lengths[w]; c++) begin
                if (pos < width && src < gtj_pkg::MAX_LINE)
                    line_buf[pos] = held_letters[src];
                pos++;
                src++;
            end
        end
        for (int i = 0; i < width; i++) begin
            r.out_ch    = line_buf[i];
            r.line_end  = (i == width - 1);
            r.text_done = (i == width - 1) && last;
            expected_chars.insert(expected_chars.size(), r);
        end
        held_words        = 0;
        held_letter_total = 0;
    endtask

    // Advances the predictor by one accepted character.
    task automatic predict_char(input gtj_pkg::t_in_item it);
        int unsigned width;
        int unsigned len;
        width = effective_width();
        if (word_buf_len < width && word_buf_len < gtj_pkg::MAX_LINE) begin
            word_buf[word_buf_len] = it.ch;
            word_buf_len++;
        end
        if (it.word_end) begin
            len = (word_buf_len < width) ? word_buf_len : width;
            if (held_words > 0 && (held_words >= gtj_pkg::MAX_WORDS ||
                                   held_letter_total + held_words + len > width))
                queue_line(held_words == 1, 1'b0);
            for (int i = 0; i < len; i++)
                if (held_letter_total + i < gtj_pkg::MAX_LINE)
                    held_letters[held_letter_total + i] = word_buf[i];
            if (held_words < gtj_pkg::MAX_WORDS) begin
                held_lengths[held_words] = len[5:0];
                held_words++;
            end
            held_letter_total = (held_letter_total + len) & 8'hFF;
            word_buf_len      = 0;
            if (it.text_end) queue_line(1'b1, 1'b1);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // Input driver: bursts with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push     <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (i_push && !o_full) begin
                predict_char(i_item);
                void'(item_queue.pop_front());
            end
            if (i_push && o_full) begin
                i_push <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_push   <= 1'b0;
            end else if (item_queue.size() > ((i_push && !o_full) ? 1 : 0) ||
                         (item_queue.size() > 0 && !(i_push && !o_full))) begin
                i_item <= (i_push && !o_full) ? item_queue[1] : item_queue[0];
                i_push <= 1'b1;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(30, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop       <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected char", o_item.out_ch, 8'h00);
                end else begin
                    if (o_item.out_ch !== expected_chars[0].out_ch)
                        report_mismatch("out_ch", o_item.out_ch, expected_chars[0].out_ch);
                    if (o_item.line_end !== expected_chars[0].line_end)
                        report_mismatch("line_end", o_item.line_end,
                                        expected_chars[0].line_end);
                    if (o_item.text_done !== expected_chars[0].text_done)
                        report_mismatch("text_done", o_item.text_done,
                                        expected_chars[0].text_done);
                    void'(expected_chars.pop_front());
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            if (hold_off_left > 0) begin
                hold_off_left <= hold_off_left - 1;
                i_pop         <= 1'b0;
            end else if (stall_phase < 10) begin
                i_pop <= 1'b1;
            end else begin
                i_pop <= ($urandom_range(2, 0) != 0);
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    task automatic add_word(input int len, input bit last);
        gtj_pkg::t_in_item it;
        for (int i = 0; i < len; i++) begin
            it.ch       = 8'($urandom_range(255, 0));
            it.word_end = (i == len - 1);
            it.text_end = (i == len - 1) ? last : 1'($urandom_range(1, 0));
            enqueue_item(it);
        end
    endtask

    task automatic wait_idle();
        while (item_queue.size() > 0 || i_push || expected_chars.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [5:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_width  = value;
        @(posedge i_clk);
    endtask

    // Random texts: mostly well-formed words, some overlong words.
    task automatic add_random_texts(input int chars, input int max_len);
        int total;
        int len;
        total = 0;
        while (total < chars) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1)
                                              : $urandom_range(max_len, 1);
            add_word(len, $urandom_range(11, 0) == 0);
            total += len;
        end
        add_word(1, 1'b1);
    endtask

    initial begin
        logic [5:0] widths [6];
        i_rst_n           = 1'b0;
        i_push            = 1'b0;
        i_pop             = 1'b0;
        i_item            = '0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = gtj_pkg::WIDTH_RESET;
        cfg_width         = gtj_pkg::WIDTH_RESET;
        held_words        = 0;
        held_letter_total = 0;
        word_buf_len      = 0;
        error_count       = 0;
        idle_cycles       = 0;
        hold_off_left     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset width, extreme bytes, one-word line, overlong word,
        // word limit and a stray text_end flag.
        enqueue_item('{ch: 8'h00, word_end: 1'b0, text_end: 1'b1});
        enqueue_item('{ch: 8'hFF, word_end: 1'b1, text_end: 1'b0});
        add_word(3, 1'b0);
        add_word(2, 1'b0);
        add_word(20, 1'b0);
        add_word(4, 1'b1);
        wait_idle();
        write_width(6'd32);
        for (int i = 0; i < 17; i++) add_word(1, i == 16);
        wait_idle();

        // Long receiver hold-off while the sender keeps going.
        hold_off_left = 400;
        add_random_texts(48, 6);
        wait_idle();

        // Random phases across widths, extremes and out-of-range values included.
        widths = '{6'd1, 6'd0, 6'd63, 6'd10, 6'd2, 6'd16};
        foreach (widths[k]) begin
            write_width(widths[k]);
            add_random_texts(48, (widths[k] < 4) ? 3 : 8);
            wait_idle();
        end

        // Width changed in the middle of a text.
        write_width(6'd20);
        for (int i = 0; i < 5; i++) add_word(3, 1'b0);
        while (item_queue.size() > 0 || i_push) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_width(6'd5);
        add_word(2, 1'b1);
        wait_idle();

        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/gtj_pkg.sv
design/gtj_front.sv
design/gtj_outq.sv
design/gtj_back.sv
design/greedy_text_justifier_core.sv
sim/greedy_text_justifier_core_tb.sv
